FILE: rtl/cmos_rtc_register_file_macros.svh
// ----------------------------------------------------------------------------
// CMOS RTC register file - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CMOS_RTC_REGISTER_FILE_MACROS_SVH
`define CMOS_RTC_REGISTER_FILE_MACROS_SVH

// Same-cycle implication.
`define CMOSRTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmosrtc: same-cycle check failed");

// Next-cycle implication.
`define CMOSRTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmosrtc: next-cycle check failed");

`endif

FILE: rtl/cmosrtc_pkg.sv
// ----------------------------------------------------------------------------
// CMOS RTC package
// Field widths, register indexes, reset bytes, item and timer control types,
// BCD and periodic-rate helpers shared by the register file.
// ----------------------------------------------------------------------------
package cmosrtc_pkg;

    localparam int STORE_BYTES_DEF = 128;
    localparam int INDEX_W         = 7;
    localparam int OP_W            = 3;
    localparam int BYTE_W          = 8;
    localparam int SEC_W           = 6;
    localparam int MIN_W           = 6;
    localparam int HOUR_W          = 5;
    localparam int WDAY_W          = 3;
    localparam int MDAY_W          = 5;
    localparam int MON_W           = 4;
    localparam int YEAR_W          = 14;
    localparam int TIMER_W         = 13;
    localparam int BCD_VAL_W       = 7;   // binary value 0..99 before BCD
    localparam int RATE_W          = 4;

    // year / 100 == (year * YEAR_RECIP) >> YEAR_SHIFT for every 14-bit year
    localparam int YEAR_RECIP = 5243;
    localparam int YEAR_SHIFT = 19;
    localparam int YEAR_PROD_W = YEAR_W + 13;
    localparam int CENT_Q_W    = 8;
    localparam int HUNDRED     = 100;

    typedef enum logic [OP_W-1:0] {
        OP_INDEX_WR  = 3'd0,
        OP_DATA_WR   = 3'd1,
        OP_INDEX_RD  = 3'd2,
        OP_DATA_RD   = 3'd3,
        OP_TICK      = 3'd4,
        OP_DEV_RESET = 3'd5
    } t_op;

    // Store indexes with special handling
    localparam logic [INDEX_W-1:0] IDX_SEC     = 7'h00;
    localparam logic [INDEX_W-1:0] IDX_MIN     = 7'h02;
    localparam logic [INDEX_W-1:0] IDX_HOUR    = 7'h04;
    localparam logic [INDEX_W-1:0] IDX_WDAY    = 7'h06;
    localparam logic [INDEX_W-1:0] IDX_MDAY    = 7'h07;
    localparam logic [INDEX_W-1:0] IDX_MON     = 7'h08;
    localparam logic [INDEX_W-1:0] IDX_YEAR    = 7'h09;
    localparam logic [INDEX_W-1:0] IDX_A       = 7'h0A;
    localparam logic [INDEX_W-1:0] IDX_B       = 7'h0B;
    localparam logic [INDEX_W-1:0] IDX_C       = 7'h0C;
    localparam logic [INDEX_W-1:0] IDX_D       = 7'h0D;
    localparam logic [INDEX_W-1:0] IDX_FLOPPY  = 7'h10;
    localparam logic [INDEX_W-1:0] IDX_CENTURY = 7'h32;

    localparam logic [BYTE_W-1:0] RST_A      = 8'h26;
    localparam logic [BYTE_W-1:0] RST_B      = 8'h02;
    localparam logic [BYTE_W-1:0] RST_D      = 8'h80;
    localparam logic [BYTE_W-1:0] FLOPPY_144 = 8'h40;
    localparam logic [BYTE_W-1:0] PORT_FLOAT = 8'hFF;

    localparam int NMI_BIT   = 7;
    localparam int A_UIP_BIT = 7;
    localparam int B_PIE_BIT = 6;
    localparam int C_PF_BIT  = 6;
    localparam int C_IRQ_BIT = 7;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] write_data;
        logic [SEC_W-1:0]  now_seconds;
        logic [MIN_W-1:0]  now_minutes;
        logic [HOUR_W-1:0] now_hours;
        logic [WDAY_W-1:0] now_weekday;
        logic [MDAY_W-1:0] now_day_of_month;
        logic [MON_W-1:0]  now_month;
        logic [YEAR_W-1:0] now_year;
    } t_item;

    typedef struct packed {
        logic               clear;
        logic               tick;
        logic               rearm;
        logic               run;
        logic [TIMER_W-1:0] period;
    } t_timer_ctrl;

    // Two BCD digits of a value below 100
    function automatic logic [BYTE_W-1:0] to_bcd(input logic [BCD_VAL_W-1:0] v);
        logic [14:0]          p;
        logic [3:0]           tens;
        logic [BCD_VAL_W-1:0] units;
        p     = 15'(v) * 15'd205;
        tens  = p[14:11];
        units = v - BCD_VAL_W'(tens) * BCD_VAL_W'(10);
        return {tens, units[3:0]};
    endfunction

    function automatic logic is_time_idx(input logic [INDEX_W-1:0] idx);
        return (idx == IDX_SEC)  || (idx == IDX_MIN)  || (idx == IDX_HOUR) ||
               (idx == IDX_WDAY) || (idx == IDX_MDAY) || (idx == IDX_MON)  ||
               (idx == IDX_YEAR) || (idx == IDX_CENTURY);
    endfunction

    // Period in ms: 2^(n-1) * 10000 / 32768, at least 1; codes 1 and 2 act as 8 and 9
    function automatic logic [TIMER_W-1:0] rate_period(input logic [RATE_W-1:0] code);
        logic [TIMER_W-1:0] ms;
        case (code)
            4'd1:    ms = 13'd39;
            4'd2:    ms = 13'd78;
            4'd3:    ms = 13'd1;
            4'd4:    ms = 13'd2;
            4'd5:    ms = 13'd4;
            4'd6:    ms = 13'd9;
            4'd7:    ms = 13'd19;
            4'd8:    ms = 13'd39;
            4'd9:    ms = 13'd78;
            4'd10:   ms = 13'd156;
            4'd11:   ms = 13'd312;
            4'd12:   ms = 13'd625;
            4'd13:   ms = 13'd1250;
            4'd14:   ms = 13'd2500;
            4'd15:   ms = 13'd5000;
            default: ms = 13'd1;
        endcase
        return ms;
    endfunction

endpackage

FILE: rtl/cmosrtc_if.sv
// ----------------------------------------------------------------------------
// CMOS RTC channel interfaces
// Valid/ready command channel (port accesses, ticks, resets) and response
// channel (read byte, interrupt level, NMI-disable state).
// ----------------------------------------------------------------------------
interface cmosrtc_cmd_if import cmosrtc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] write_data;
    logic [SEC_W-1:0]  now_seconds;
    logic [MIN_W-1:0]  now_minutes;
    logic [HOUR_W-1:0] now_hours;
    logic [WDAY_W-1:0] now_weekday;
    logic [MDAY_W-1:0] now_day_of_month;
    logic [MON_W-1:0]  now_month;
    logic [YEAR_W-1:0] now_year;

    modport source (
        output valid, operation, write_data, now_seconds, now_minutes, now_hours,
               now_weekday, now_day_of_month, now_month, now_year,
        input  ready
    );
    modport sink (
        input  valid, operation, write_data, now_seconds, now_minutes, now_hours,
               now_weekday, now_day_of_month, now_month, now_year,
        output ready
    );
endinterface

interface cmosrtc_rsp_if import cmosrtc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              irq_level;
    logic              nmi_masked;

    modport source (output valid, read_data, irq_level, nmi_masked, input ready);
    modport sink   (input valid, read_data, irq_level, nmi_masked, output ready);
endinterface

FILE: rtl/cmosrtc_ram.sv
// ----------------------------------------------------------------------------
// CMOS RTC generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cmosrtc_ram import cmosrtc_pkg::*; #(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = STORE_BYTES_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cmosrtc_time_bcd.sv
// ----------------------------------------------------------------------------
// CMOS RTC time encoder
// Two-stage pipeline turning the host time fields into the BCD byte of the
// selected time register; the year is split by a reciprocal multiply.
// ----------------------------------------------------------------------------
module cmosrtc_time_bcd import cmosrtc_pkg::*; (
    input  logic               i_clk,
    input  logic [INDEX_W-1:0] i_index,
    input  t_item              i_item,
    output logic [BYTE_W-1:0]  o_bcd
);

    typedef enum logic [1:0] {
        TS_SMALL,
        TS_YEAR,
        TS_CENT
    } t_tsel;

    logic [YEAR_PROD_W-1:0] year_prod;
    logic [BCD_VAL_W-1:0]   small_val;
    t_tsel                  sel;
    logic [YEAR_W-1:0]      year_rem;
    logic [BCD_VAL_W-1:0]   cent_val;
    logic [BCD_VAL_W-1:0]   n_val;

    logic [CENT_Q_W-1:0]  r_q;
    logic [YEAR_W-1:0]    r_year;
    logic [BCD_VAL_W-1:0] r_small;
    t_tsel                r_sel;
    logic [BCD_VAL_W-1:0] r_val;

    always_comb begin
        year_prod = YEAR_PROD_W'(i_item.now_year) * YEAR_PROD_W'(YEAR_RECIP);
        small_val = '0;
        sel       = TS_SMALL;
        case (i_index)
            IDX_SEC:     small_val = BCD_VAL_W'(i_item.now_seconds);
            IDX_MIN:     small_val = BCD_VAL_W'(i_item.now_minutes);
            IDX_HOUR:    small_val = BCD_VAL_W'(i_item.now_hours);
            IDX_WDAY:    small_val = BCD_VAL_W'(i_item.now_weekday) + BCD_VAL_W'(1);
            IDX_MDAY:    small_val = BCD_VAL_W'(i_item.now_day_of_month);
            IDX_MON:     small_val = BCD_VAL_W'(i_item.now_month) + BCD_VAL_W'(1);
            IDX_YEAR:    sel = TS_YEAR;
            IDX_CENTURY: sel = TS_CENT;
            default:     small_val = '0;
        endcase
    end

    // Stage two: year remainder and century mod 100
    always_comb begin
        year_rem = r_year - YEAR_W'(r_q) * YEAR_W'(HUNDRED);
        cent_val = (r_q >= CENT_Q_W'(HUNDRED)) ? BCD_VAL_W'(r_q - CENT_Q_W'(HUNDRED))
                                               : BCD_VAL_W'(r_q);
        case (r_sel)
            TS_YEAR: n_val = year_rem[BCD_VAL_W-1:0];
            TS_CENT: n_val = cent_val;
            default: n_val = r_small;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q     <= CENT_Q_W'(year_prod >> YEAR_SHIFT);
        r_year  <= i_item.now_year;
        r_small <= small_val;
        r_sel   <= sel;
        r_val   <= n_val;
    end

    assign o_bcd = to_bcd(r_val);

endmodule

FILE: rtl/cmosrtc_timer.sv
// ----------------------------------------------------------------------------
// CMOS RTC periodic timer
// Millisecond counter with re-arm, stop and clear; flags a periodic event
// in the cycle of the tick that reaches the period.
// ----------------------------------------------------------------------------
`include "cmos_rtc_register_file_macros.svh"

module cmosrtc_timer import cmosrtc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_timer_ctrl i_ctrl,
    output logic        o_fire
);

    logic               r_running, n_running;
    logic [TIMER_W-1:0] r_elapsed, n_elapsed;
    logic [TIMER_W-1:0] r_period,  n_period;
    logic [TIMER_W-1:0] elapsed_inc;

    assign elapsed_inc = r_elapsed + TIMER_W'(1);
    assign o_fire      = i_ctrl.tick && r_running && (elapsed_inc >= r_period);

    always_comb begin
        n_running = r_running;
        n_elapsed = r_elapsed;
        n_period  = r_period;
        if (i_ctrl.clear) begin
            n_running = 1'b0;
            n_elapsed = '0;
            n_period  = '0;
        end else if (i_ctrl.rearm) begin
            n_running = i_ctrl.run;
            if (i_ctrl.run) begin
                n_period  = i_ctrl.period;
                n_elapsed = '0;
            end
        end else if (i_ctrl.tick && r_running) begin
            n_elapsed = o_fire ? '0 : elapsed_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_elapsed <= '0;
            r_period  <= '0;
        end else begin
            r_running <= n_running;
            r_elapsed <= n_elapsed;
            r_period  <= n_period;
        end
    end

    `CMOSRTC_ASSERT_IMP(a_run_below_period, i_clk, i_rst_n, r_running, r_elapsed < r_period)
    `CMOSRTC_ASSERT_NXT(a_rearm_restarts, i_clk, i_rst_n, !i_ctrl.clear && i_ctrl.rearm && i_ctrl.run, r_running && r_elapsed == '0)
    `CMOSRTC_ASSERT_NXT(a_clear_stops, i_clk, i_rst_n, i_ctrl.clear, !r_running && r_period == '0)

endmodule

FILE: rtl/cmos_rtc_register_file.sv
// ----------------------------------------------------------------------------
// CMOS RTC register file
// Every item (index write, data write, index-port read, data read,
// millisecond tick, device reset) passes from acceptance to its result being
// loaded into the output register through S_EXEC, which decodes, updates the
// state and issues the store read (the store's registered read and the first
// stage of the time encoder complete at its end), S_MID, for the encoder's
// second stage, and S_RESP, which forms the result and waits there while the
// output register still holds an untaken response. The block is back in idle
// once the result is loaded and takes a new item in the following cycle, even
// while the result still waits at the output. Registers A to C live in
// flip-flops and D reads as its fixed value; the other bytes sit in a
// single-port-write RAM with per-byte valid bits, so power-on and device reset
// take effect at once with no clearing pass. Time bytes are produced as BCD
// from the item's host time fields on every data read of a time index.
// ----------------------------------------------------------------------------
`include "cmos_rtc_register_file_macros.svh"

module cmos_rtc_register_file import cmosrtc_pkg::*; #(
    parameter int STORE_BYTES = STORE_BYTES_DEF    // 64 .. 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    cmosrtc_cmd_if.sink   i_cmd,
    cmosrtc_rsp_if.source o_rsp
);

    localparam int AW    = $clog2(STORE_BYTES);
    localparam int CMP_W = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MID,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        RS_ZERO,
        RS_FLOAT,
        RS_BYTE,
        RS_RAM,
        RS_TIME
    } t_rsrc;

    // Control state
    t_state             r_state, n_state;
    logic [INDEX_W-1:0] r_index, n_index;
    logic               r_nmi, n_nmi;
    logic               r_irq, n_irq;
    logic [BYTE_W-1:0]  r_reg_a, n_reg_a;
    logic [BYTE_W-1:0]  r_reg_b, n_reg_b;
    logic [BYTE_W-1:0]  r_reg_c, n_reg_c;
    logic [STORE_BYTES-1:0] r_valid, n_valid;
    logic               r_floppy_cfg;
    logic               r_floppy_rst, n_floppy_rst;
    logic               r_out_valid, n_out_valid;

    // Payload
    t_item              r_item, n_item;
    t_rsrc              r_rd_src, n_rd_src;
    logic [BYTE_W-1:0]  r_rd_byte, n_rd_byte;
    logic               r_rd_valid, n_rd_valid;
    logic [BYTE_W-1:0]  r_out_data, n_out_data;
    logic               r_out_irq, n_out_irq;
    logic               r_out_nmi, n_out_nmi;

    logic               cmd_accept;
    logic               out_load;
    logic [AW-1:0]      addr;
    logic               in_range;
    logic               ram_we;
    logic               ram_re;
    logic [BYTE_W-1:0]  ram_rdata;
    logic [BYTE_W-1:0]  time_bcd;
    logic               fire;
    t_timer_ctrl        timer_ctrl;
    logic [BYTE_W-1:0]  c_fired;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;
    assign out_load    = (r_state == S_RESP) && (!r_out_valid || o_rsp.ready);
    assign addr        = AW'(r_index);
    assign in_range    = (CMP_W'(r_index) < CMP_W'(STORE_BYTES));

    cmosrtc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (r_item.write_data),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    cmosrtc_time_bcd u_time (
        .i_clk   (i_clk),
        .i_index (r_index),
        .i_item  (r_item),
        .o_bcd   (time_bcd)
    );

    cmosrtc_timer u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (timer_ctrl),
        .o_fire  (fire)
    );

    always_comb begin
        n_state      = r_state;
        n_index      = r_index;
        n_nmi        = r_nmi;
        n_irq        = r_irq;
        n_reg_a      = r_reg_a;
        n_reg_b      = r_reg_b;
        n_reg_c      = r_reg_c;
        n_valid      = r_valid;
        n_floppy_rst = r_floppy_rst;
        n_out_valid  = r_out_valid;
        n_item       = r_item;
        n_rd_src     = r_rd_src;
        n_rd_byte    = r_rd_byte;
        n_rd_valid   = r_rd_valid;
        n_out_data   = r_out_data;
        n_out_irq    = r_out_irq;
        n_out_nmi    = r_out_nmi;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        timer_ctrl   = '0;
        c_fired      = r_reg_c;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (cmd_accept) begin
                    n_item.operation        = i_cmd.operation;
                    n_item.write_data       = i_cmd.write_data;
                    n_item.now_seconds      = i_cmd.now_seconds;
                    n_item.now_minutes      = i_cmd.now_minutes;
                    n_item.now_hours        = i_cmd.now_hours;
                    n_item.now_weekday      = i_cmd.now_weekday;
                    n_item.now_day_of_month = i_cmd.now_day_of_month;
                    n_item.now_month        = i_cmd.now_month;
                    n_item.now_year         = i_cmd.now_year;
                    n_state                 = S_EXEC;
                end
            end
            S_EXEC: begin
                n_rd_src = RS_ZERO;
                n_state  = S_MID;
                case (r_item.operation)
                    OP_INDEX_WR: begin
                        n_index = r_item.write_data[INDEX_W-1:0];
                        n_nmi   = r_item.write_data[NMI_BIT];
                    end
                    OP_DATA_WR: begin
                        if (r_index == IDX_A || r_index == IDX_B) begin
                            // keep update-in-progress, then re-arm with new A and B when the rate is nonzero
                            if (r_index == IDX_A) begin
                                n_reg_a = {r_reg_a[A_UIP_BIT],
                                           r_item.write_data[BYTE_W-2:0]};
                            end else begin
                                n_reg_b = r_item.write_data;
                            end
                            timer_ctrl.rearm  = (n_reg_a[RATE_W-1:0] != '0);
                            timer_ctrl.run    = n_reg_b[B_PIE_BIT];
                            timer_ctrl.period = rate_period(n_reg_a[RATE_W-1:0]);
                        end else if (r_index != IDX_C && r_index != IDX_D && in_range) begin
                            ram_we        = 1'b1;
                            n_valid[addr] = 1'b1;
                        end
                    end
                    OP_INDEX_RD: begin
                        n_rd_src = RS_FLOAT;
                    end
                    OP_DATA_RD: begin
                        if (r_index == IDX_C) begin
                            // read-to-clear; drop the interrupt
                            n_rd_src  = RS_BYTE;
                            n_rd_byte = r_reg_c;
                            n_reg_c   = '0;
                            n_irq     = 1'b0;
                        end else if (is_time_idx(r_index)) begin
                            n_rd_src = RS_TIME;
                        end else if (r_index == IDX_A) begin
                            n_rd_src  = RS_BYTE;
                            n_rd_byte = r_reg_a;
                        end else if (r_index == IDX_B) begin
                            n_rd_src  = RS_BYTE;
                            n_rd_byte = r_reg_b;
                        end else if (r_index == IDX_D) begin
                            n_rd_src  = RS_BYTE;
                            n_rd_byte = RST_D;
                        end else if (!in_range) begin
                            n_rd_src = RS_FLOAT;
                        end else begin
                            // never-written bytes read back their reset value
                            n_rd_src   = RS_RAM;
                            ram_re     = 1'b1;
                            n_rd_valid = r_valid[addr];
                            n_rd_byte  = (r_index == IDX_FLOPPY && r_floppy_rst)
                                         ? FLOPPY_144 : '0;
                        end
                    end
                    OP_TICK: begin
                        timer_ctrl.tick = 1'b1;
                        if (fire) begin
                            c_fired[C_PF_BIT] = 1'b1;
                            if (r_reg_b[B_PIE_BIT] && !r_reg_c[C_IRQ_BIT]) begin
                                c_fired[C_IRQ_BIT] = 1'b1;
                                n_irq              = 1'b1;
                            end
                            n_reg_c = c_fired;
                        end
                    end
                    OP_DEV_RESET: begin
                        timer_ctrl.clear = 1'b1;
                        n_index          = '0;
                        n_nmi            = 1'b0;
                        n_irq            = 1'b0;
                        n_reg_a          = RST_A;
                        n_reg_b          = RST_B;
                        n_reg_c          = '0;
                        n_valid          = '0;
                        n_floppy_rst     = r_floppy_cfg;
                    end
                    default: begin
                        n_rd_src = RS_ZERO;
                    end
                endcase
            end
            S_MID: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_load) begin
                    case (r_rd_src)
                        RS_FLOAT: n_out_data = PORT_FLOAT;
                        RS_BYTE:  n_out_data = r_rd_byte;
                        RS_RAM:   n_out_data = r_rd_valid ? ram_rdata : r_rd_byte;
                        RS_TIME:  n_out_data = time_bcd;
                        default:  n_out_data = '0;
                    endcase
                    n_out_irq   = r_irq;
                    n_out_nmi   = r_nmi;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_index      <= '0;
            r_nmi        <= 1'b0;
            r_irq        <= 1'b0;
            r_reg_a      <= RST_A;
            r_reg_b      <= RST_B;
            r_reg_c      <= '0;
            r_valid      <= '0;
            r_floppy_cfg <= 1'b0;
            r_floppy_rst <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_index      <= n_index;
            r_nmi        <= n_nmi;
            r_irq        <= n_irq;
            r_reg_a      <= n_reg_a;
            r_reg_b      <= n_reg_b;
            r_reg_c      <= n_reg_c;
            r_valid      <= n_valid;
            r_floppy_rst <= n_floppy_rst;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_floppy_cfg <= i_cfg_wdata;
            end
        end
        r_item     <= n_item;
        r_rd_src   <= n_rd_src;
        r_rd_byte  <= n_rd_byte;
        r_rd_valid <= n_rd_valid;
        r_out_data <= n_out_data;
        r_out_irq  <= n_out_irq;
        r_out_nmi  <= n_out_nmi;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_data  = r_out_data;
    assign o_rsp.irq_level  = r_out_irq;
    assign o_rsp.nmi_masked = r_out_nmi;

    `CMOSRTC_ASSERT_IMP(a_irq_has_flag, i_clk, i_rst_n, r_irq, r_reg_c[C_IRQ_BIT])
    `CMOSRTC_ASSERT_IMP(a_store_write_op, i_clk, i_rst_n, ram_we, r_state == S_EXEC && r_item.operation == OP_DATA_WR && in_range)
    `CMOSRTC_ASSERT_NXT(a_accept_to_exec, i_clk, i_rst_n, cmd_accept, r_state == S_EXEC && r_out_valid == $past(r_out_valid && !o_rsp.ready))

endmodule
